### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CUR_W-1:0]  cur_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CELL_W-1:0] cell_t;

  // character codes and reset attribute
  localparam char_t CH_NEWLINE   = 8'd10;
  localparam char_t CH_BACKSPACE = 8'd8;
  localparam char_t CH_BLANK     = 8'd32;
  localparam char_t ATTR_RESET   = 8'd15;

  // derived constants
  localparam cur_t  CUR_CELLS      = cur_t'(CELLS);
  localparam cur_t  CUR_LAST_ROW   = cur_t'(CELLS - COLUMNS);
  localparam cur_t  CUR_COLUMNS    = cur_t'(COLUMNS);
  localparam col_t  COL_LAST       = col_t'(COLUMNS - 1);
  localparam addr_t ADDR_COLUMNS   = addr_t'(COLUMNS);
  localparam addr_t ADDR_COPY_LAST = addr_t'(CELLS - COLUMNS - 1);
  localparam addr_t ADDR_LAST      = addr_t'(CELLS - 1);

  // item function codes
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // store write source
  typedef enum logic [2:0] {
    WSEL_NONE,
    WSEL_PUT,
    WSEL_COPY,
    WSEL_INIT,
    WSEL_FILL
  } wsel_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  exec;
    logic  cnt_zero;
    logic  cnt_inc;
    logic  scroll_rd;
    wsel_t wsel;
    logic  cursor_clear;
    logic  load_out;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  wrap;
    logic  cnt_copy_last;
    logic  cnt_last;
  } tcw_sts_t;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::tcw_cmd_t  cmd,
  input  tcw_pkg::tcw_sts_t  sts
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SC_RD,
    S_SC_WR,
    S_FILL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    cmd        = '0;
    cmd.wsel   = tcw_pkg::WSEL_NONE;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.wsel = tcw_pkg::WSEL_INIT;
        if (sts.cnt_last) begin
          cmd.cnt_zero = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.func) inside
          tcw_pkg::FUNC_PUT: begin
            cmd.wsel = tcw_pkg::WSEL_PUT;
            if (sts.wrap) begin
              cmd.cnt_zero = 1'b1;
              state_next   = S_SC_RD;
            end else begin
              state_next = S_DONE;
            end
          end
          tcw_pkg::FUNC_CLEAR: begin
            cmd.cnt_zero     = 1'b1;
            cmd.cursor_clear = 1'b1;
            state_next       = S_FILL;
          end
          tcw_pkg::FUNC_READ, tcw_pkg::FUNC_NONE: begin
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SC_RD: begin
        cmd.scroll_rd = 1'b1;
        state_next    = S_SC_WR;
      end
      S_SC_WR: begin
        cmd.wsel    = tcw_pkg::WSEL_COPY;
        cmd.cnt_inc = 1'b1;
        state_next  = sts.cnt_copy_last ? S_FILL : S_SC_RD;
      end
      S_FILL: begin
        cmd.wsel = tcw_pkg::WSEL_FILL;
        if (sts.cnt_last) begin
          state_next = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  // state and handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      in_stall  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_stall  <= (state_next != S_IDLE);
      out_valid <= cmd.load_out || (out_valid && out_stall);
    end
  end

  // a result appears only from the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion state");

  // a finished item waits while the previous result is stalled
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> state == S_DONE)
    else $error("result overwritten while output stalled");

endmodule

`default_nettype wire

### rtl/core/tcw_dp.sv
`default_nettype none

module tcw_dp (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_sts_t sts,
  input  logic [1:0]        func,
  input  logic [7:0]        char_code,
  input  logic [10:0]       cell_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output logic [10:0]       cursor_position,
  output logic [7:0]        read_char,
  output logic [7:0]        read_attribute,
  output logic              scrolled
);

  tcw_pkg::char_t attr;
  tcw_pkg::cur_t  cursor;
  tcw_pkg::col_t  col;
  tcw_pkg::addr_t cnt;
  tcw_pkg::func_t item_func;
  tcw_pkg::char_t item_char;
  logic           item_in_range;
  tcw_pkg::char_t res_char;
  tcw_pkg::char_t res_attr;
  logic           res_scrolled;

  tcw_pkg::cur_t  cur_nl;
  tcw_pkg::cur_t  cur_dec;
  tcw_pkg::cur_t  cur_inc;
  tcw_pkg::cur_t  cursor_put;
  tcw_pkg::col_t  col_put;
  logic           put_we;
  tcw_pkg::addr_t put_addr;
  tcw_pkg::cell_t put_data;
  logic           wrap;

  logic           wr_en;
  tcw_pkg::addr_t wr_addr;
  tcw_pkg::cell_t wr_data;
  tcw_pkg::addr_t rd_addr;
  tcw_pkg::cell_t rd_data;

  assign cfg_ready = 1'b1;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr <= cfg_data;
    end
  end

  // cursor moves for a put
  assign cur_nl  = cursor + tcw_pkg::CUR_COLUMNS - tcw_pkg::cur_t'(col);
  assign cur_dec = cursor - tcw_pkg::cur_t'(1);
  assign cur_inc = cursor + tcw_pkg::cur_t'(1);

  always_comb begin
    cursor_put = cursor;
    col_put    = col;
    put_we     = 1'b0;
    put_addr   = cursor[tcw_pkg::ADDR_W-1:0];
    put_data   = {attr, item_char};
    if (item_char == tcw_pkg::CH_NEWLINE) begin
      cursor_put = cur_nl;
      col_put    = '0;
    end else if (item_char == tcw_pkg::CH_BACKSPACE) begin
      if (cursor != '0) begin
        cursor_put = cur_dec;
        col_put    = (col == '0) ? tcw_pkg::COL_LAST : col - 1'b1;
        put_we     = 1'b1;
        put_addr   = cur_dec[tcw_pkg::ADDR_W-1:0];
        put_data   = {attr, tcw_pkg::CH_BLANK};
      end
    end else begin
      cursor_put = cur_inc;
      col_put    = (col == tcw_pkg::COL_LAST) ? '0 : col + 1'b1;
      put_we     = 1'b1;
    end
  end

  assign wrap = (cursor_put == tcw_pkg::CUR_CELLS);

  // status back to the controller
  assign sts.func          = item_func;
  assign sts.wrap          = (item_func == tcw_pkg::FUNC_PUT) && wrap;
  assign sts.cnt_copy_last = (cnt == tcw_pkg::ADDR_COPY_LAST);
  assign sts.cnt_last      = (cnt == tcw_pkg::ADDR_LAST);

  // cursor and column
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      col    <= '0;
    end else if (cmd.cursor_clear) begin
      cursor <= '0;
      col    <= '0;
    end else if (cmd.exec && item_func == tcw_pkg::FUNC_PUT) begin
      cursor <= wrap ? tcw_pkg::CUR_LAST_ROW : cursor_put;
      col    <= col_put;
    end
  end

  // sweep counter for clear, scroll and reset fill
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_zero) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func     <= tcw_pkg::func_t'(func);
      item_char     <= char_code;
      item_in_range <= (32'(cell_index) < tcw_pkg::CELLS);
    end
  end

  // per item result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_char     <= '0;
      res_attr     <= '0;
      res_scrolled <= 1'b0;
    end else if (cmd.exec) begin
      if (item_func == tcw_pkg::FUNC_READ && item_in_range) begin
        res_char <= rd_data[tcw_pkg::CHAR_W-1:0];
        res_attr <= rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
      if (item_func == tcw_pkg::FUNC_PUT && wrap) begin
        res_scrolled <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_position <= tcw_pkg::pos_t'(cursor);
      read_char       <= res_char;
      read_attribute  <= res_attr;
      scrolled        <= res_scrolled;
    end
  end

  // store port selection
  assign rd_addr = cmd.scroll_rd ? cnt + tcw_pkg::ADDR_COLUMNS
                                 : cell_index[tcw_pkg::ADDR_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = {attr, tcw_pkg::CH_BLANK};
    case (cmd.wsel)
      tcw_pkg::WSEL_PUT: begin
        wr_en   = put_we;
        wr_addr = put_addr;
        wr_data = put_data;
      end
      tcw_pkg::WSEL_COPY: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      tcw_pkg::WSEL_INIT: begin
        wr_en   = 1'b1;
        wr_data = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_BLANK};
      end
      tcw_pkg::WSEL_FILL: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // cursor stays on screen between items
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor < tcw_pkg::CUR_CELLS)
    else $error("cursor beyond last cell");

  // column stays within a row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= tcw_pkg::COL_LAST)
    else $error("column beyond last column");

  // every store write lands inside the screen
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> wr_addr <= tcw_pkg::ADDR_LAST)
    else $error("store write out of range");

endmodule

`default_nettype wire

### rtl/core/text_console_writer_core.sv
`default_nettype none

// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    func, char_code, cell_index
// out       source     out_valid / out_stall  cursor_position, read_char,
//                                             read_attribute, scrolled
// cfg       sink       cfg_valid / cfg_ready  cfg_data (text attribute)
//
// put, read and unused codes go from transfer in through execute and completion to result ready
// a put that scrolls first copies every cell below the top row one row up,
// reading then writing each cell, then fills the bottom row with blanks
// a clear homes the cursor and fills every cell with blanks
// after reset the store is filled with blanks, in_stall high;
// configuration writes are taken during that fill
// a new item is taken while the previous result still waits on out_stall

module text_console_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] cursor_position,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attribute,
  output logic        scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  // sequencer
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // cursor, cell store and result registers
  tcw_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .func            (func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .cursor_position (cursor_position),
    .read_char       (read_char),
    .read_attribute  (read_attribute),
    .scrolled        (scrolled)
  );

endmodule

`default_nettype wire
